// ===== sv/best_fit_block_allocator_defines.svh =====
// Assertion macros used by the allocator RTL.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define BFBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define BFBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define BFBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bfba_pkg.sv =====
package bfba_pkg;

    localparam int BFBA_MAX_BLOCKS = 16;
    localparam int SIZE_W          = 16;
    localparam int OWNER_W         = 8;
    localparam int NUM_OUT_W       = 5;

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_ALLOC = 2'd1,
        FN_CLEAR = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              active;
        logic              found;
        logic [SIZE_W-1:0] size;
    } t_carry;

endpackage

// ===== sv/best_fit_block_allocator.sv =====
// Best-fit block allocator. Blocks are added in order (numbered from 1) and held in a
// row of cells, one block per cell. An add, a clear or an unknown function code yields
// its result beat in the cycle after acceptance. An allocate sends a search token down the
// cell row, one cell per cycle, and registers its beat once the token has left the last cell
// and the output register is free or being drained; the grant picks the smallest free
// block that fits, lowest number on ties. A new beat is taken once the previous item has
// finished and the output register is free or being drained. s_tuser carries the function
// code; the result beat has the status in the low bits of m_tdata.
`include "best_fit_block_allocator_defines.svh"

module best_fit_block_allocator #(
    parameter int MAX_BLOCKS = bfba_pkg::BFBA_MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // size[15:0], requester[23:16]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], block_number[6:2], block_size[22:7], zero[23]
);
    import bfba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int NUM_W = (CNT_W > NUM_OUT_W) ? CNT_W : NUM_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_inject, n_inject;
    logic                 r_out_valid, n_out_valid;
    logic [23:0]          r_out_data, n_out_data;
    logic [SIZE_W-1:0]    r_req_size;
    logic [OWNER_W-1:0]   r_requester;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_W-1:0]    r_best_size;

    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_full;
    logic                 w_add_wr;
    logic                 w_grant;
    logic [NUM_W-1:0]     w_add_num;
    logic [NUM_W-1:0]     w_grant_num;
    logic [SIZE_W-1:0]    w_in_size;
    logic [OWNER_W-1:0]   w_in_req;

    t_carry               w_carry [MAX_BLOCKS+1];
    logic [IDX_W-1:0]     w_cidx  [MAX_BLOCKS+1];

    assign w_in_size   = s_tdata[15:0];
    assign w_in_req    = s_tdata[23:16];
    assign w_slot_free = !r_out_valid || m_tready;
    assign s_tready    = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = s_tvalid && s_tready;
    assign w_full      = (r_count == CNT_W'(MAX_BLOCKS));
    assign w_add_wr    = w_accept && (t_func'(s_tuser) == FN_ADD) && !w_full;
    assign w_grant     = (r_state == S_DONE) && w_slot_free && r_found;
    assign w_add_num   = NUM_W'(r_count) + NUM_W'(1);
    assign w_grant_num = NUM_W'(r_best_idx) + NUM_W'(1);

    assign w_carry[0] = '{active: r_inject, found: 1'b0, size: '0};
    assign w_cidx[0]  = '0;

    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        localparam logic [CNT_W-1:0] K_CNT = CNT_W'(k);
        localparam logic [IDX_W-1:0] K_IDX = IDX_W'(k);

        bfba_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_live     (r_count > K_CNT),
            .i_wr       (w_add_wr && (r_count == K_CNT)),
            .i_wr_size  (w_in_size),
            .i_grant    (w_grant && (r_best_idx == K_IDX)),
            .i_owner    (r_requester),
            .i_req_size (r_req_size),
            .i_cin      (w_carry[k]),
            .i_cin_idx  (w_cidx[k]),
            .o_cout     (w_carry[k+1]),
            .o_cout_idx (w_cidx[k+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_inject    = 1'b0;
        n_out_valid = r_out_valid && !m_tready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_func'(s_tuser))
                        FN_ADD: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_data = {1'b0, 16'd0, 5'd0, ST_FULL};
                            end else begin
                                n_count    = r_count + CNT_W'(1);
                                n_out_data = {1'b0, w_in_size, w_add_num[NUM_OUT_W-1:0], ST_OK};
                            end
                        end
                        FN_ALLOC: begin
                            n_inject = 1'b1;
                            n_state  = S_SEARCH;
                        end
                        FN_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                            n_out_data  = {1'b0, 16'd0, 5'd0, ST_OK};
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = {1'b0, 16'd0, 5'd0, ST_OK};
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_carry[MAX_BLOCKS].active) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_found) begin
                        n_out_data = {1'b0, r_best_size, w_grant_num[NUM_OUT_W-1:0], ST_OK};
                    end else begin
                        n_out_data = {1'b0, 16'd0, 5'd0, ST_NOFIT};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_inject    <= n_inject;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_req_size  <= w_in_size;
            r_requester <= w_in_req;
        end
        if (w_carry[MAX_BLOCKS].active) begin
            r_found     <= w_carry[MAX_BLOCKS].found;
            r_best_idx  <= w_cidx[MAX_BLOCKS];
            r_best_size <= w_carry[MAX_BLOCKS].size;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    `BFBA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_BLOCKS))
    `BFBA_ASSERT_IMP(a_inject_in_search, i_clk, i_rst_n, r_inject, r_state == S_SEARCH)
    `BFBA_ASSERT_IMP(a_token_in_search, i_clk, i_rst_n, w_carry[MAX_BLOCKS].active, r_state == S_SEARCH)
    `BFBA_ASSERT_IMP(a_fit_size, i_clk, i_rst_n, w_carry[MAX_BLOCKS].active && w_carry[MAX_BLOCKS].found, w_carry[MAX_BLOCKS].size >= r_req_size)
    `BFBA_ASSERT_NXT(a_done_leaves, i_clk, i_rst_n, (r_state == S_DONE) && w_slot_free, m_tvalid && (r_state == S_IDLE))

endmodule

// ===== sv/bfba_cell.sv =====
module bfba_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_live,
    input  logic                          i_wr,
    input  logic [bfba_pkg::SIZE_W-1:0]   i_wr_size,
    input  logic                          i_grant,
    input  logic [bfba_pkg::OWNER_W-1:0]  i_owner,
    input  logic [bfba_pkg::SIZE_W-1:0]   i_req_size,
    input  bfba_pkg::t_carry              i_cin,
    input  logic [IDX_W-1:0]              i_cin_idx,
    output bfba_pkg::t_carry              o_cout,
    output logic [IDX_W-1:0]              o_cout_idx
);
    import bfba_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_W-1:0]  r_size;
    logic [OWNER_W-1:0] r_owner;
    t_carry             r_cout;
    logic [IDX_W-1:0]   r_cout_idx;
    logic               w_take;

    assign w_take = i_cin.active && i_live && (r_owner == '0) && (r_size >= i_req_size)
                    && (!i_cin.found || (r_size < i_cin.size));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_size  <= i_wr_size;
            r_owner <= '0;
        end else if (i_grant) begin
            r_owner <= i_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cout.active <= 1'b0;
        end else begin
            r_cout.active <= i_cin.active;
        end
        r_cout.found <= i_cin.found | w_take;
        r_cout.size  <= w_take ? r_size : i_cin.size;
        r_cout_idx   <= w_take ? MY_IDX : i_cin_idx;
    end

    assign o_cout     = r_cout;
    assign o_cout_idx = r_cout_idx;

endmodule
